// ===== sv/upd_pkg.sv =====
// Shared types and constants for the up/down digital potentiometer controller.
`default_nettype none

package upd_pkg;

    // Wiper range and field widths.
    localparam int unsigned MAX_POSITION = 99;
    localparam int unsigned POS_W        = 7;
    localparam int unsigned VAL_W        = 20;
    localparam int unsigned CNT_W        = 8;
    localparam int unsigned PROD_W       = VAL_W + POS_W;

    // Reset value of the full-scale resistance register, in ohms.
    localparam logic [VAL_W-1:0] NOMINAL_RESET = VAL_W'(10000);

    // Command codes.
    typedef enum logic [2:0] {
        OP_SET_POS   = 3'd0,
        OP_SET_RES   = 3'd1,
        OP_STEP_UP   = 3'd2,
        OP_STEP_DOWN = 3'd3,
        OP_STORE     = 3'd4,
        OP_READ      = 3'd5
    } opcode_t;

    // Operand selection for the shared multiply-add.
    typedef enum logic {
        SEL_TARGET = 1'b0,
        SEL_OHMS   = 1'b1
    } div_sel_t;

    // Request payload.
    typedef struct packed {
        logic [2:0]       opcode;
        logic [VAL_W-1:0] value;
    } in_item_t;

    // Response payload.
    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] position;
        logic             position_known;
        logic             direction;
        logic [CNT_W-1:0] pulse_count;
        logic             stored;
        logic [VAL_W-1:0] resistance;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     latch_in;
        logic     div_start;
        div_sel_t div_sel;
        logic     apply;
        logic     load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic res_path;
        logic div_done;
        logic ohm_done;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/upd_div.sv =====
// Bit-serial restoring divider for the ohms-to-position conversion.
`default_nettype none

module upd_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [upd_pkg::PROD_W-1:0]     dividend,
    input  wire logic [upd_pkg::VAL_W-1:0]      divisor,
    output logic      [upd_pkg::PROD_W-1:0]     quotient,
    output logic                                done
);

    localparam int unsigned CNT_BITS = $clog2(upd_pkg::PROD_W);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [CNT_BITS-1:0]            count_reg, count_next;
    logic [upd_pkg::PROD_W-1:0]     quo_reg, quo_next;
    logic [upd_pkg::VAL_W-1:0]      rem_reg, rem_next;
    logic [upd_pkg::VAL_W-1:0]      divisor_reg, divisor_next;
    logic [upd_pkg::VAL_W:0]        trial;
    logic                           fits;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    assign trial = {rem_reg, quo_reg[upd_pkg::PROD_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            count_next   = CNT_BITS'(upd_pkg::PROD_W - 1);
            quo_next     = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[upd_pkg::PROD_W-2:0], fits};
            rem_next = fits ? upd_pkg::VAL_W'(trial - {1'b0, divisor_reg})
                            : trial[upd_pkg::VAL_W-1:0];
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== sv/upd_dp.sv =====
// Datapath: wiper tracking, nominal resistance register, conversions and result register.
`default_nettype none

module upd_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [upd_pkg::VAL_W-1:0]   cfg_wdata,
    input  wire upd_pkg::in_item_t           in_data,
    input  wire upd_pkg::ctrl_cmd_t          cmd,
    output upd_pkg::dp_status_t              status,
    output upd_pkg::out_item_t               out_data
);

    localparam logic [upd_pkg::POS_W-1:0] MAX_POS  = upd_pkg::POS_W'(upd_pkg::MAX_POSITION);
    localparam logic [upd_pkg::CNT_W-1:0] MAX_CNT  = upd_pkg::CNT_W'(upd_pkg::MAX_POSITION);
    localparam logic [upd_pkg::VAL_W-1:0] MAX_VAL  = upd_pkg::VAL_W'(upd_pkg::MAX_POSITION);
    localparam logic [upd_pkg::VAL_W-1:0] HALF_MAX = upd_pkg::VAL_W'(upd_pkg::MAX_POSITION / 2);

    // Reciprocal of the maximum position, rounded up; exact for any dividend of PROD_W bits.
    localparam int unsigned OHM_SHIFT = upd_pkg::PROD_W + upd_pkg::POS_W;
    localparam int unsigned RECIP_W   = upd_pkg::PROD_W + 1;
    localparam int unsigned OPROD_W   = upd_pkg::PROD_W + RECIP_W;
    localparam logic [63:0] RECIP_64  = ((64'd1 << OHM_SHIFT) + 64'(upd_pkg::MAX_POSITION)
                                         - 64'd1) / 64'(upd_pkg::MAX_POSITION);
    localparam logic [RECIP_W-1:0] OHM_RECIP = RECIP_W'(RECIP_64);

    logic [upd_pkg::VAL_W-1:0]  nominal_reg;
    logic [2:0]                 op_reg;
    logic [upd_pkg::VAL_W-1:0]  value_reg;
    logic [upd_pkg::POS_W-1:0]  wiper_pos_reg, wiper_pos_next;
    logic                       wiper_known_reg, wiper_known_next;
    logic                       ok_reg, ok_next;
    logic                       dir_reg, dir_next;
    logic [upd_pkg::CNT_W-1:0]  pulses_reg, pulses_next;
    logic                       stored_reg, stored_next;
    upd_pkg::out_item_t         out_reg, out_next;

    logic [upd_pkg::VAL_W-1:0]  mul_a, mul_c;
    logic [upd_pkg::POS_W-1:0]  mul_b;
    logic [upd_pkg::PROD_W-1:0] product;
    logic [upd_pkg::PROD_W-1:0] quotient;
    logic                       div_done;
    logic                       div_start;
    logic                       ohm_start;
    logic [upd_pkg::PROD_W-1:0] ohm_num_reg;
    logic                       ohm_mul_reg;
    logic [upd_pkg::VAL_W-1:0]  ohm_quo_reg;
    logic [OPROD_W-1:0]         ohm_prod;
    logic                       pos_ok;
    logic                       res_path;
    logic                       moves;
    logic                       home;
    logic [upd_pkg::POS_W-1:0]  target;
    logic [upd_pkg::POS_W-1:0]  p0;
    logic [upd_pkg::CNT_W-1:0]  base;
    logic                       nominal_set;

    // Request checks on the latched command.
    assign nominal_set = nominal_reg != '0;
    assign pos_ok      = value_reg <= MAX_VAL;
    assign res_path    = (op_reg == upd_pkg::OP_SET_RES) && nominal_set
                         && (value_reg <= nominal_reg);

    // Shared multiply-add: value * MAX + nominal / 2 for the divider, or
    // position * nominal + MAX / 2 for the resistance readback.
    always_comb
    begin
        if (cmd.div_sel == upd_pkg::SEL_OHMS)
        begin
            mul_a = nominal_reg;
            mul_b = wiper_pos_reg;
            mul_c = HALF_MAX;
        end
        else
        begin
            mul_a = value_reg;
            mul_b = MAX_POS;
            mul_c = {1'b0, nominal_reg[upd_pkg::VAL_W-1:1]};
        end
    end

    assign product = upd_pkg::PROD_W'(mul_a) * upd_pkg::PROD_W'(mul_b)
                     + upd_pkg::PROD_W'(mul_c);

    assign div_start = cmd.div_start && (cmd.div_sel == upd_pkg::SEL_TARGET);
    assign ohm_start = cmd.div_start && (cmd.div_sel == upd_pkg::SEL_OHMS);

    upd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (nominal_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // Readback division by the maximum position: reciprocal multiply and shift.
    assign ohm_prod = OPROD_W'(ohm_num_reg) * OPROD_W'(OHM_RECIP);

    // Wiper move: homing run first when the position is unknown, then the command's run.
    always_comb
    begin
        moves = ((op_reg == upd_pkg::OP_SET_POS) && pos_ok) || res_path
                || (op_reg == upd_pkg::OP_STEP_UP) || (op_reg == upd_pkg::OP_STEP_DOWN);
        home  = moves && !wiper_known_reg;
        p0    = home ? '0 : wiper_pos_reg;
        base  = home ? MAX_CNT : '0;
        target = (op_reg == upd_pkg::OP_SET_RES) ? quotient[upd_pkg::POS_W-1:0]
                                                 : value_reg[upd_pkg::POS_W-1:0];

        wiper_pos_next   = p0;
        wiper_known_next = wiper_known_reg | moves;
        dir_next         = 1'b0;
        pulses_next      = base;
        ok_next          = 1'b0;
        stored_next      = 1'b0;

        case (op_reg)
            upd_pkg::OP_SET_POS, upd_pkg::OP_SET_RES:
            begin
                ok_next = moves;
                if (moves)
                begin
                    wiper_pos_next = target;
                    if (p0 > target)
                    begin
                        pulses_next = base + upd_pkg::CNT_W'(p0 - target);
                    end
                    else if (p0 < target)
                    begin
                        pulses_next = base + upd_pkg::CNT_W'(target - p0);
                        dir_next    = 1'b1;
                    end
                end
            end
            upd_pkg::OP_STEP_UP:
            begin
                ok_next = 1'b1;
                if (p0 < MAX_POS)
                begin
                    wiper_pos_next = p0 + 1'b1;
                    pulses_next    = base + 1'b1;
                    dir_next       = 1'b1;
                end
            end
            upd_pkg::OP_STEP_DOWN:
            begin
                ok_next = 1'b1;
                if (p0 != '0)
                begin
                    wiper_pos_next = p0 - 1'b1;
                    pulses_next    = base + 1'b1;
                end
            end
            upd_pkg::OP_STORE:
            begin
                ok_next     = 1'b1;
                stored_next = 1'b1;
            end
            upd_pkg::OP_READ:
            begin
                ok_next = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // Result assembly.
    always_comb
    begin
        out_next.ok             = ok_reg;
        out_next.position       = wiper_pos_reg;
        out_next.position_known = wiper_known_reg;
        out_next.direction      = dir_reg;
        out_next.pulse_count    = pulses_reg;
        out_next.stored         = stored_reg;
        out_next.resistance     = (wiper_known_reg && nominal_set) ? ohm_quo_reg : '0;
    end

    // Control state: configuration register, tracked wiper and readback step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_reg     <= upd_pkg::NOMINAL_RESET;
            wiper_pos_reg   <= '0;
            wiper_known_reg <= 1'b0;
            ohm_mul_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                nominal_reg <= cfg_wdata;
            end
            if (cmd.apply)
            begin
                wiper_pos_reg   <= wiper_pos_next;
                wiper_known_reg <= wiper_known_next;
            end
            ohm_mul_reg <= ohm_start;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg    <= in_data.opcode;
            value_reg <= in_data.value;
        end
        if (cmd.apply)
        begin
            ok_reg     <= ok_next;
            dir_reg    <= dir_next;
            pulses_reg <= pulses_next;
            stored_reg <= stored_next;
        end
        if (ohm_start)
        begin
            ohm_num_reg <= product;
        end
        if (ohm_mul_reg)
        begin
            ohm_quo_reg <= ohm_prod[OHM_SHIFT +: upd_pkg::VAL_W];
        end
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    // Status to the controller.
    always_comb
    begin
        status.res_path = res_path;
        status.div_done = div_done;
        status.ohm_done = ohm_mul_reg;
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// ===== sv/upd_ctrl.sv =====
// Controller: sequences each request through conversion, wiper update and result hand-off.
`default_nettype none

module upd_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 out_stall,
    input  wire upd_pkg::dp_status_t  status,
    output upd_pkg::ctrl_cmd_t        cmd,
    output logic                      in_stall,
    output logic                      out_valid
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_QRES  = 7'b0000010,
        S_WRES  = 7'b0000100,
        S_MOVE  = 7'b0001000,
        S_QOHM  = 7'b0010000,
        S_WOHM  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // The result register can take a new result once the old one is gone or leaving.
    assign out_free = !out_valid_reg || !out_stall;

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        cmd.latch_in  = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_sel   = upd_pkg::SEL_TARGET;
        cmd.apply     = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.latch_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_QRES;
                end
            end
            S_QRES:
            begin
                cmd.div_start = status.res_path;
                state_next    = status.res_path ? S_WRES : S_MOVE;
            end
            S_WRES:
            begin
                if (status.div_done)
                begin
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                cmd.apply  = 1'b1;
                state_next = S_QOHM;
            end
            S_QOHM:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = upd_pkg::SEL_OHMS;
                state_next    = S_WOHM;
            end
            S_WOHM:
            begin
                cmd.div_sel = upd_pkg::SEL_OHMS;
                if (status.ohm_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                cmd.div_sel  = upd_pkg::SEL_OHMS;
                cmd.load_out = out_free;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid holds until the downstream side takes it.
    assign out_valid_next = cmd.load_out || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== sv/updown_digital_pot_controller.sv =====
// Top level of the up/down digital potentiometer controller.
`default_nettype none

// Takes one request at a time and answers each with one response. The
// response is presented once the request has passed the check, wiper update,
// resistance readback and output states; a set resistance that passes its
// checks first waits for its ohms-to-position conversion, which runs a
// bit-serial divider. The resistance readback divides by the maximum position
// with a registered reciprocal multiply. A new request is taken from the cycle
// after the response is loaded, even while that response still waits in the
// output register; a stalled output holds a second response back until the
// first one is taken. The wiper is tracked, not driven: the first command that
// moves an unknown wiper counts a full downward homing run. nominal_resistance
// may be written only while idle.
module updown_digital_pot_controller (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [upd_pkg::VAL_W-1:0]   cfg_wdata,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire upd_pkg::in_item_t           in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output upd_pkg::out_item_t               out_data
);

    upd_pkg::ctrl_cmd_t  cmd;
    upd_pkg::dp_status_t status;

    upd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    upd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

    // A request in progress blocks the next one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while another was in progress");

    // The tracked wiper never leaves its range.
    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.position <= upd_pkg::POS_W'(upd_pkg::MAX_POSITION))
        else $error("wiper position beyond its maximum");

    // No resistance is reported for an unknown wiper.
    a_unknown_ohms: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.position_known |-> out_data.resistance == '0)
        else $error("resistance reported for an unknown wiper");

    // A refused command issues no pulses and no store.
    a_refused_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.ok |-> out_data.pulse_count == '0 && !out_data.stored)
        else $error("refused command issued pulses or a store");

endmodule

`default_nettype wire
